### src/cstl_pkg.sv
// Shared types, token codes, keyword table and character classes of the lexer.
`default_nettype none

package cstl_pkg;

    localparam int KIND_W       = 6;
    localparam int OUT_LINE_W   = 16;
    localparam int OUT_COL_W    = 12;
    localparam int LEN_W        = 8;
    localparam int KW_NUM       = 8;
    localparam int KW_TEXT_MAX  = 6;

    localparam logic [OUT_LINE_W-1:0] OUT_LINE_TOP = {OUT_LINE_W{1'b1}};
    localparam logic [OUT_COL_W-1:0]  OUT_COL_TOP  = {OUT_COL_W{1'b1}};
    localparam logic [LEN_W-1:0]      LEN_TOP      = {LEN_W{1'b1}};

    // Input item kinds.
    typedef enum logic [1:0] {
        FUNC_CHAR = 2'd0,
        FUNC_LINE = 2'd1,
        FUNC_EOI  = 2'd2,
        FUNC_RSVD = 2'd3
    } func_t;

    // Class of the token that is still being assembled.
    typedef enum logic [2:0] {
        P_NONE = 3'd0,
        P_INT  = 3'd1,
        P_DOT  = 3'd2,
        P_REAL = 3'd3,
        P_WORD = 3'd4,
        P_EQ   = 3'd5,
        P_BANG = 3'd6,
        P_AMP  = 3'd7
    } pend_t;

    // Token kinds.
    localparam logic [KIND_W-1:0] K_INVALID = 6'd0;
    localparam logic [KIND_W-1:0] K_EOF     = 6'd1;
    localparam logic [KIND_W-1:0] K_INT     = 6'd2;
    localparam logic [KIND_W-1:0] K_REAL    = 6'd3;
    localparam logic [KIND_W-1:0] K_IDENT   = 6'd4;
    localparam logic [KIND_W-1:0] K_KW0     = 6'd5;
    localparam logic [KIND_W-1:0] K_COMMA   = 6'd13;
    localparam logic [KIND_W-1:0] K_PLUS    = 6'd14;
    localparam logic [KIND_W-1:0] K_MINUS   = 6'd15;
    localparam logic [KIND_W-1:0] K_STAR    = 6'd16;
    localparam logic [KIND_W-1:0] K_SLASH   = 6'd17;
    localparam logic [KIND_W-1:0] K_PERCENT = 6'd18;
    localparam logic [KIND_W-1:0] K_EQ      = 6'd19;
    localparam logic [KIND_W-1:0] K_EQEQ    = 6'd20;
    localparam logic [KIND_W-1:0] K_LT      = 6'd21;
    localparam logic [KIND_W-1:0] K_GT      = 6'd22;
    localparam logic [KIND_W-1:0] K_BANG    = 6'd23;
    localparam logic [KIND_W-1:0] K_BANGEQ  = 6'd24;
    localparam logic [KIND_W-1:0] K_AMP     = 6'd25;
    localparam logic [KIND_W-1:0] K_AMPAMP  = 6'd26;
    localparam logic [KIND_W-1:0] K_SEMI    = 6'd27;
    localparam logic [KIND_W-1:0] K_LPAREN  = 6'd28;
    localparam logic [KIND_W-1:0] K_RPAREN  = 6'd29;
    localparam logic [KIND_W-1:0] K_LBRACK  = 6'd30;
    localparam logic [KIND_W-1:0] K_RBRACK  = 6'd31;
    localparam logic [KIND_W-1:0] K_LBRACE  = 6'd32;
    localparam logic [KIND_W-1:0] K_RBRACE  = 6'd33;

    // Keywords in kind order, zero padded.
    localparam logic [7:0] KW_TEXT [KW_NUM][KW_TEXT_MAX] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"d", "o", "u", "b", "l", "e"},
        '{"v", "o", "i", "d", 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00},
        '{"r", "e", "t", "u", "r", "n"}
    };
    localparam logic [LEN_W-1:0] KW_LEN [KW_NUM] = '{
        8'd3, 8'd6, 8'd4, 8'd2, 8'd4, 8'd3, 8'd5, 8'd6
    };

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [OUT_LINE_W-1:0] line;
        logic [OUT_COL_W-1:0]  column;
        logic [LEN_W-1:0]      length;
        logic                  last;
    } token_t;

    // Up to two tokens caused by one input item.
    typedef struct packed {
        logic [1:0] n;
        token_t     tok0;
        token_t     tok1;
    } pair_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) || (c == 8'h0C) ||
               (c == 8'h0D) || (c == 8'h20);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic [KIND_W-1:0] single_symbol(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        unique case (c)
            ",":     k = K_COMMA;
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            "%":     k = K_PERCENT;
            "<":     k = K_LT;
            ">":     k = K_GT;
            ";":     k = K_SEMI;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "[":     k = K_LBRACK;
            "]":     k = K_RBRACK;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            default: k = K_INVALID;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

### src/cstl_lex.sv
// Lexer state and the single-pass step that turns one input item into up to two tokens.
`default_nettype none

module cstl_lex
    import cstl_pkg::*;
#(
    parameter int KEYWORD_MAX = 6,
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        step_en,
    input  func_t      func,
    input  wire  [7:0] ch,
    output pair_t      pair
);

    localparam int LW = (LINE_BITS > OUT_LINE_W) ? LINE_BITS : OUT_LINE_W;
    localparam int CW = (COLUMN_BITS > OUT_COL_W) ? COLUMN_BITS : OUT_COL_W;

    pend_t                  pend_reg, pend_next;
    logic [LEN_W-1:0]       count_reg, count_next;
    logic [7:0]             text_reg  [KEYWORD_MAX];
    logic [7:0]             text_next [KEYWORD_MAX];
    logic [LINE_BITS-1:0]   start_line_reg, start_line_next;
    logic [COLUMN_BITS-1:0] start_col_reg, start_col_next;
    logic [LINE_BITS-1:0]   cur_line_reg, cur_line_next;
    logic [COLUMN_BITS-1:0] cur_col_reg, cur_col_next;

    logic [LW-1:0]          sl_w, cl_w;
    logic [CW-1:0]          sc_w, cc_w;
    logic [OUT_LINE_W-1:0]  start_line_out, cur_line_out;
    logic [OUT_COL_W-1:0]   start_col_out, cur_col_out;

    logic                   kw_hit;
    logic [KIND_W-1:0]      kw_kind;
    logic [KIND_W-1:0]      class_kind;

    logic                   close_en, kw_ok, dbl, fresh_go, new_en;
    logic [KIND_W-1:0]      dbl_kind, new_kind;
    logic [LEN_W-1:0]       new_len, grown;
    token_t                 tok_close, tok_new;

    // Positions saturate to the width of the result fields.
    assign sl_w = LW'(start_line_reg);
    assign cl_w = LW'(cur_line_reg);
    assign sc_w = CW'(start_col_reg);
    assign cc_w = CW'(cur_col_reg);
    assign start_line_out = (sl_w > LW'(OUT_LINE_TOP)) ? OUT_LINE_TOP : sl_w[OUT_LINE_W-1:0];
    assign cur_line_out   = (cl_w > LW'(OUT_LINE_TOP)) ? OUT_LINE_TOP : cl_w[OUT_LINE_W-1:0];
    assign start_col_out  = (sc_w > CW'(OUT_COL_TOP)) ? OUT_COL_TOP : sc_w[OUT_COL_W-1:0];
    assign cur_col_out    = (cc_w > CW'(OUT_COL_TOP)) ? OUT_COL_TOP : cc_w[OUT_COL_W-1:0];

    assign grown = (count_reg != LEN_TOP) ? count_reg + LEN_W'(1) : count_reg;

    // All eight keywords are compared against the run buffer in parallel.
    always_comb begin
        logic m;
        kw_hit  = 1'b0;
        kw_kind = K_IDENT;
        for (int k = 0; k < KW_NUM; k++) begin
            m = (KW_LEN[k] == count_reg) && (KW_LEN[k] <= LEN_W'(KEYWORD_MAX));
            for (int i = 0; i < KW_TEXT_MAX; i++) begin
                if ((LEN_W'(i) < KW_LEN[k]) && (text_reg[i] != KW_TEXT[k][i])) begin
                    m = 1'b0;
                end
            end
            if (m && !kw_hit) begin
                kw_hit  = 1'b1;
                kw_kind = K_KW0 + KIND_W'(k);
            end
        end
    end

    always_comb begin
        unique case (pend_reg)
            P_INT:   class_kind = K_INT;
            P_DOT:   class_kind = K_INVALID;
            P_REAL:  class_kind = K_REAL;
            P_WORD:  class_kind = (kw_ok && kw_hit) ? kw_kind : K_IDENT;
            P_EQ:    class_kind = K_EQ;
            P_BANG:  class_kind = K_BANG;
            P_AMP:   class_kind = K_AMP;
            default: class_kind = K_INVALID;
        endcase
    end

    always_comb begin
        pend_next       = pend_reg;
        count_next      = count_reg;
        text_next       = text_reg;
        start_line_next = start_line_reg;
        start_col_next  = start_col_reg;
        cur_line_next   = cur_line_reg;
        cur_col_next    = cur_col_reg;
        close_en        = 1'b0;
        kw_ok           = 1'b0;
        dbl             = 1'b0;
        dbl_kind        = K_INVALID;
        fresh_go        = 1'b0;
        new_en          = 1'b0;
        new_kind        = K_INVALID;
        new_len         = LEN_W'(1);

        unique case (func)
            FUNC_CHAR: begin
                unique case (pend_reg)
                    P_INT: begin
                        if (is_digit(ch)) begin
                            count_next = grown;
                        end else if (ch == ".") begin
                            count_next = grown;
                            pend_next  = P_DOT;
                        end else begin
                            close_en = 1'b1;
                            fresh_go = 1'b1;
                        end
                    end
                    P_DOT, P_REAL: begin
                        if (is_digit(ch)) begin
                            count_next = grown;
                            pend_next  = P_REAL;
                        end else begin
                            close_en = 1'b1;
                            fresh_go = 1'b1;
                        end
                    end
                    P_WORD: begin
                        if (is_word(ch)) begin
                            for (int i = 0; i < KEYWORD_MAX; i++) begin
                                if (count_reg == LEN_W'(i)) begin
                                    text_next[i] = ch;
                                end
                            end
                            count_next = grown;
                        end else begin
                            // Here only whitespace after the run lets it be a keyword.
                            close_en = 1'b1;
                            kw_ok    = is_ws(ch);
                            fresh_go = 1'b1;
                        end
                    end
                    P_EQ, P_BANG: begin
                        close_en = 1'b1;
                        if (ch == "=") begin
                            dbl      = 1'b1;
                            dbl_kind = (pend_reg == P_EQ) ? K_EQEQ : K_BANGEQ;
                        end else begin
                            fresh_go = 1'b1;
                        end
                    end
                    P_AMP: begin
                        close_en = 1'b1;
                        if (ch == "&") begin
                            dbl      = 1'b1;
                            dbl_kind = K_AMPAMP;
                        end else begin
                            fresh_go = 1'b1;
                        end
                    end
                    P_NONE: begin
                        fresh_go = 1'b1;
                    end
                endcase
                if (cur_col_reg != {COLUMN_BITS{1'b1}}) begin
                    cur_col_next = cur_col_reg + COLUMN_BITS'(1);
                end
            end
            FUNC_LINE: begin
                close_en     = (pend_reg != P_NONE);
                kw_ok        = 1'b1;
                cur_col_next = '0;
                if (cur_line_reg != {LINE_BITS{1'b1}}) begin
                    cur_line_next = cur_line_reg + LINE_BITS'(1);
                end
            end
            FUNC_EOI: begin
                close_en      = (pend_reg != P_NONE);
                kw_ok         = 1'b1;
                new_en        = 1'b1;
                new_kind      = K_EOF;
                new_len       = '0;
                cur_line_next = '0;
                cur_col_next  = '0;
            end
            FUNC_RSVD: begin
            end
        endcase

        if (close_en) begin
            pend_next  = P_NONE;
            count_next = '0;
        end

        // The character is lexed afresh once nothing is pending any more.
        if (fresh_go && !is_ws(ch) && (ch != 8'h00)) begin
            if (is_digit(ch) || (ch == ".") || is_word(ch) ||
                (ch == "=") || (ch == "!") || (ch == "&")) begin
                count_next      = LEN_W'(1);
                start_line_next = cur_line_reg;
                start_col_next  = cur_col_reg;
                if (is_digit(ch)) begin
                    pend_next = P_INT;
                end else if (ch == ".") begin
                    pend_next = P_DOT;
                end else if (is_word(ch)) begin
                    pend_next    = P_WORD;
                    text_next[0] = ch;
                end else if (ch == "=") begin
                    pend_next = P_EQ;
                end else if (ch == "!") begin
                    pend_next = P_BANG;
                end else begin
                    pend_next = P_AMP;
                end
            end else begin
                new_en   = 1'b1;
                new_kind = single_symbol(ch);
            end
        end
    end

    always_comb begin
        tok_close.kind   = dbl ? dbl_kind : class_kind;
        tok_close.line   = start_line_out;
        tok_close.column = start_col_out;
        tok_close.length = dbl ? LEN_W'(2) : count_reg;
        tok_close.last   = !new_en;
        tok_new.kind     = new_kind;
        tok_new.line     = cur_line_out;
        tok_new.column   = cur_col_out;
        tok_new.length   = new_len;
        tok_new.last     = 1'b1;
        if (close_en) begin
            pair.n    = new_en ? 2'd2 : 2'd1;
            pair.tok0 = tok_close;
        end else begin
            pair.n    = new_en ? 2'd1 : 2'd0;
            pair.tok0 = tok_new;
        end
        pair.tok1 = tok_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg       <= P_NONE;
            count_reg      <= '0;
            start_line_reg <= '0;
            start_col_reg  <= '0;
            cur_line_reg   <= '0;
            cur_col_reg    <= '0;
            for (int i = 0; i < KEYWORD_MAX; i++) begin
                text_reg[i] <= '0;
            end
        end else if (step_en) begin
            pend_reg       <= pend_next;
            count_reg      <= count_next;
            text_reg       <= text_next;
            start_line_reg <= start_line_next;
            start_col_reg  <= start_col_next;
            cur_line_reg   <= cur_line_next;
            cur_col_reg    <= cur_col_next;
        end
    end

`ifndef ASSERT_OFF
    a_eoi_rewinds: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && (func == FUNC_EOI)) |=> (cur_line_reg == '0) && (cur_col_reg == '0))
        else $error("end of input did not rewind the position");

    a_eoi_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && (func == FUNC_EOI)) |=> (pend_reg == P_NONE) && (count_reg == '0))
        else $error("end of input left a token pending");
`endif

endmodule

`default_nettype wire

### src/cstl_outq.sv
// Two-entry token buffer that hands the tokens of one item out one transaction at a time.
`default_nettype none

module cstl_outq
    import cstl_pkg::*;
(
    input  wire    aclk,
    input  wire    aresetn,
    input  wire    push,
    input  pair_t  pair,
    output logic   ready,
    output logic   m_valid,
    input  wire    m_ready,
    output token_t head
);

    logic [1:0] cnt_reg, cnt_next;
    token_t     q0_reg, q0_next;
    token_t     q1_reg, q1_next;
    logic       pop;

    assign pop     = (cnt_reg != 2'd0) && m_ready;
    // A new pair may enter only when the buffer is empty after this cycle's transaction.
    assign ready   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);
    assign m_valid = (cnt_reg != 2'd0);
    assign head    = q0_reg;

    always_comb begin
        if (push) begin
            cnt_next = pair.n;
            q0_next  = pair.tok0;
            q1_next  = pair.tok1;
        end else begin
            cnt_next = cnt_reg - {1'b0, pop};
            q0_next  = pop ? q1_reg : q0_reg;
            q1_next  = q1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("token buffer count out of range");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && (pair.n == 2'd2)) |=> (cnt_reg == 2'd2) && !head.last && q1_reg.last)
        else $error("two-token item not queued in order");
`endif

endmodule

`default_nettype wire

### src/c_subset_token_lexer.sv
// Top level of the streaming lexer for a small C subset.
//
// One character, line break or end-of-input mark enters per transaction on the s_ side and
// the resulting tokens leave on the m_ side, one token per transaction, with m_tlast on the
// final token that an input item causes. An item is held in the input register and lexed in
// a single pass into a two-entry token buffer, from which its first token is offered on the
// m_ side. Items that cause at most one token are taken at one per cycle while m_tready is
// high; an item that causes two tokens occupies the token buffer until its second token is
// leaving, which holds the next item in the input register meanwhile. The token buffer's single
// output port thus sets the rate: one token per cycle while m_tready is high.
`default_nettype none

module c_subset_token_lexer
    import cstl_pkg::*;
#(
    parameter int KEYWORD_MAX = 6,
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 12
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] ch
    input  wire  [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // [15:0] token_line, [27:16] token_column,
                                   // [35:28] token_length, [39:36] zero
    output logic [5:0]  m_tuser,   // [5:0] token_kind
    output logic        m_tlast    // last token of the input item
);

    logic       in_valid_reg, in_valid_next;
    func_t      in_func_reg;
    logic [7:0] in_ch_reg;
    logic       s_fire, step_en, q_ready;
    pair_t      pair;
    token_t     head;

    assign step_en       = in_valid_reg && q_ready;
    assign s_tready      = !in_valid_reg || step_en;
    assign s_fire        = s_tvalid && s_tready;
    assign in_valid_next = s_fire ? 1'b1 : (step_en ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_func_reg <= func_t'(s_tuser);
            in_ch_reg   <= s_tdata;
        end
    end

    cstl_lex #(
        .KEYWORD_MAX(KEYWORD_MAX),
        .LINE_BITS  (LINE_BITS),
        .COLUMN_BITS(COLUMN_BITS)
    ) u_lex (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step_en(step_en),
        .func   (in_func_reg),
        .ch     (in_ch_reg),
        .pair   (pair)
    );

    cstl_outq u_outq (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (step_en),
        .pair   (pair),
        .ready  (q_ready),
        .m_valid(m_tvalid),
        .m_ready(m_tready),
        .head   (head)
    );

    assign m_tdata = {4'b0000, head.length, head.column, head.line};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

`ifndef ASSERT_OFF
    a_item_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !step_en) |=> in_valid_reg && $stable(in_ch_reg))
        else $error("waiting input item was lost");
`endif

endmodule

`default_nettype wire
